/* src/assert_macros.svh */
// Assertion helpers for the RTL; split_vq_nearest_search includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

/* src/svq_pkg.sv */
package svq_pkg;

	// Default sizing of the codebook.
	localparam int NUM_SPLITS_DEF   = 4;
	localparam int BOOK_ENTRIES_DEF = 256;
	localparam int SUB_DIM_DEF      = 4;
	localparam int ELEM_BITS_DEF    = 16;

	// Number of component fields carried on the command and result ports.
	localparam int PORT_ELEMS = 4;

	// Command opcodes. Code three means nothing and is ignored.
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_QUANT   = 2'd1;
	localparam logic [1:0] OP_DEQUANT = 2'd2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [1:0]          split_sel;
		logic [7:0]          entry_sel;
		logic signed [15:0]  elem0;
		logic signed [15:0]  elem1;
		logic signed [15:0]  elem2;
		logic signed [15:0]  elem3;
	} svq_cmd_t;

	typedef struct packed {
		logic [7:0]          code_index;
		logic signed [15:0]  quant0;
		logic signed [15:0]  quant1;
		logic signed [15:0]  quant2;
		logic signed [15:0]  quant3;
	} svq_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} svq_state_t;

endpackage

/* src/split_vq_nearest_search.sv */
// Split vector-quantiser codebook with exhaustive nearest-neighbour search.
// A transaction is accepted on a rising edge with start high and busy low;
// a write stores one entry, a quantise returns the first entry of the chosen
// split with the strictly smallest sum of squared differences, and a
// dequantise returns the stored entry at an index (saturated to the last
// entry). Results appear for exactly one cycle with done high and cannot be
// held off, so the receiver must take them when they come. A write is
// stored at the accepting edge and leaves the block idle. A dequantise
// delivers its result in the cycle after acceptance. A quantise scans the
// split through the single codebook RAM port, which reads one entry per
// cycle during the scan; the drain state then waits for the distance
// pipeline to empty and fetches the winning entry. Busy is low again in the
// result cycle, so the next transaction may be accepted alongside a result.
// Entries that were never written read back as unknown data.
module split_vq_nearest_search #(
	parameter int NUM_SPLITS   = svq_pkg::NUM_SPLITS_DEF,
	parameter int BOOK_ENTRIES = svq_pkg::BOOK_ENTRIES_DEF,
	parameter int SUB_DIM      = svq_pkg::SUB_DIM_DEF,
	parameter int ELEM_BITS    = svq_pkg::ELEM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  svq_pkg::svq_cmd_t    cmd,
	output logic                 done,
	output svq_pkg::svq_result_t result
);

`include "assert_macros.svh"

	localparam int DEPTH  = NUM_SPLITS * BOOK_ENTRIES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = $clog2(BOOK_ENTRIES);
	localparam int ROW_W  = SUB_DIM * ELEM_BITS;
	localparam int DIST_W = 2 * ELEM_BITS + $clog2(SUB_DIM);
	localparam int PAD_W  = svq_pkg::PORT_ELEMS * ELEM_BITS;

	// Sequencer and scan state.
	svq_pkg::svq_state_t state_q, state_d;
	logic [IDX_W-1:0]    idx_q;
	logic [1:0]          split_q;
	logic [ROW_W-1:0]    tgt_q;

	// Running best candidate. The first valid distance always wins, so the
	// stored distance needs no reset value.
	logic                first_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [DIST_W-1:0]   best_dist_q;
	logic [IDX_W-1:0]    out_idx_q;

	// Valid and index tags travelling alongside the distance pipeline.
	logic                val_s1, val_s2, val_s3;
	logic [IDX_W-1:0]    idx_s1, idx_s2, idx_s3;

	logic                accept;
	logic                split_ok;
	logic                entry_ok;
	logic [IDX_W-1:0]    entry_sat;
	logic [ROW_W-1:0]    in_row;
	logic                pipe_empty;
	logic                last_idx;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [ROW_W-1:0]    row_s1;
	logic [DIST_W-1:0]   dist_s3;

	// Row address of an entry within a split's table.
	function automatic logic [ADDR_W-1:0] row_addr(input logic [1:0] split,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(32'(split) * 32'(BOOK_ENTRIES)) + ADDR_W'(idx);
	endfunction

	assign accept     = start && !busy;
	assign split_ok   = 32'(cmd.split_sel) < 32'(NUM_SPLITS);
	assign entry_ok   = 32'(cmd.entry_sel) < 32'(BOOK_ENTRIES);
	assign entry_sat  = entry_ok ? IDX_W'(cmd.entry_sel) : IDX_W'(BOOK_ENTRIES - 1);
	assign pipe_empty = !(val_s1 || val_s2 || val_s3);
	assign last_idx   = (idx_q == IDX_W'(BOOK_ENTRIES - 1));

	// Port fields are taken as raw bit patterns of ELEM_BITS bits. Components
	// beyond the port fields are zero.
	always_comb begin
		logic [7:0][15:0] fld;
		fld = '0;
		fld[0] = cmd.elem0;
		fld[1] = cmd.elem1;
		fld[2] = cmd.elem2;
		fld[3] = cmd.elem3;
		for (int d = 0; d < SUB_DIM; d++) begin
			in_row[d*ELEM_BITS +: ELEM_BITS] = ELEM_BITS'(fld[3'(d)]);
		end
	end

	// Next-state logic. A new transaction may start from idle or from the
	// cycle in which a result is being shown.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svq_pkg::ST_IDLE, svq_pkg::ST_OUT: begin
				state_d = svq_pkg::ST_IDLE;
				if (accept && split_ok) begin
					if (cmd.opcode == svq_pkg::OP_QUANT) begin
						state_d = svq_pkg::ST_SCAN;
					end else if (cmd.opcode == svq_pkg::OP_DEQUANT) begin
						state_d = svq_pkg::ST_OUT;
					end
				end
			end
			svq_pkg::ST_SCAN: begin
				if (last_idx) begin
					state_d = svq_pkg::ST_DRAIN;
				end
			end
			svq_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = svq_pkg::ST_OUT;
				end
			end
			default: state_d = svq_pkg::ST_IDLE;
		endcase
	end

	// Output and RAM port decoding. During the scan the RAM reads one entry
	// per cycle; once the pipeline has drained it re-reads the winner. Busy is
	// low in idle and in the result cycle, so start alone marks acceptance there.
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		ram_we   = 1'b0;
		ram_addr = row_addr(cmd.split_sel, entry_sat);
		unique case (state_q)
			svq_pkg::ST_IDLE: begin
				busy   = 1'b0;
				ram_we = start && (cmd.opcode == svq_pkg::OP_WRITE) && split_ok && entry_ok;
			end
			svq_pkg::ST_OUT: begin
				busy   = 1'b0;
				done   = 1'b1;
				ram_we = start && (cmd.opcode == svq_pkg::OP_WRITE) && split_ok && entry_ok;
			end
			svq_pkg::ST_SCAN: begin
				ram_addr = row_addr(split_q, idx_q);
			end
			svq_pkg::ST_DRAIN: begin
				ram_addr = row_addr(split_q, best_idx_q);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	svq_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_row),
		.rdata (row_s1)
	);

	svq_dist #(
		.SUB_DIM   (SUB_DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_dist (
		.clk     (clk),
		.tgt     (tgt_q),
		.row_s1  (row_s1),
		.dist_s3 (dist_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svq_pkg::ST_IDLE;
			idx_q   <= '0;
			first_q <= 1'b1;
			val_s1  <= 1'b0;
			val_s2  <= 1'b0;
			val_s3  <= 1'b0;
		end else begin
			state_q <= state_d;
			val_s1  <= (state_q == svq_pkg::ST_SCAN);
			val_s2  <= val_s1;
			val_s3  <= val_s2;
			if (accept) begin
				idx_q   <= '0;
				first_q <= 1'b1;
			end else begin
				if (state_q == svq_pkg::ST_SCAN) begin
					idx_q <= idx_q + 1'b1;
				end
				// Strict less-than keeps the earliest entry on a tie.
				if (val_s3 && (first_q || dist_s3 < best_dist_q)) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		if (accept) begin
			split_q   <= cmd.split_sel;
			tgt_q     <= in_row;
			out_idx_q <= entry_sat;
		end
		if (val_s3 && (first_q || dist_s3 < best_dist_q)) begin
			best_idx_q  <= idx_s3;
			best_dist_q <= dist_s3;
		end
		if (state_q == svq_pkg::ST_DRAIN) begin
			out_idx_q <= best_idx_q;
		end
	end

	// Result fields come straight from the registered RAM output. Stored
	// components are sign-extended or cut to the 16-bit port fields; absent
	// components read as zero from the padding.
	always_comb begin
		logic [PAD_W+ROW_W-1:0] rd_pad;
		logic [3:0][15:0]       q;
		rd_pad = {{PAD_W{1'b0}}, row_s1};
		for (int d = 0; d < svq_pkg::PORT_ELEMS; d++) begin
			q[d] = 16'($signed(rd_pad[d*ELEM_BITS +: ELEM_BITS]));
		end
		result.code_index = 8'(out_idx_q);
		result.quant0     = q[0];
		result.quant1     = q[1];
		result.quant2     = q[2];
		result.quant3     = q[3];
	end

	// A result is only shown once no scan candidate is still in flight.
	`ASSERT_SAME(a_out_after_drain, clk, arst_n, done, pipe_empty)
	// Scan candidates exist only while a quantise is in progress.
	`ASSERT_SAME(a_pipe_in_search, clk, arst_n, val_s3,
		(state_q == svq_pkg::ST_SCAN) || (state_q == svq_pkg::ST_DRAIN))
	// The codebook is never written while a search owns the RAM port.
	`ASSERT_SAME(a_no_write_busy, clk, arst_n, ram_we, !busy)
	// A valid quantise starts scanning from the first entry.
	`ASSERT_NEXT(a_scan_start, clk, arst_n,
		accept && split_ok && (cmd.opcode == svq_pkg::OP_QUANT),
		(state_q == svq_pkg::ST_SCAN) && (idx_q == '0) && first_q)

endmodule

/* src/svq_ram.sv */
module svq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* src/svq_dist.sv */
// Squared Euclidean distance between the held target and one codebook row.
// Two register stages: per-component squares, then their sum.
module svq_dist #(
	parameter int SUB_DIM   = svq_pkg::SUB_DIM_DEF,
	parameter int ELEM_BITS = svq_pkg::ELEM_BITS_DEF,
	localparam int ROW_W  = SUB_DIM * ELEM_BITS,
	localparam int SQ_W   = 2 * ELEM_BITS,
	localparam int DIST_W = SQ_W + $clog2(SUB_DIM)
) (
	input  logic              clk,
	input  logic [ROW_W-1:0]  tgt,
	input  logic [ROW_W-1:0]  row_s1,
	output logic [DIST_W-1:0] dist_s3
);

	logic [SUB_DIM-1:0][SQ_W-1:0] sq_d;
	logic [SUB_DIM-1:0][SQ_W-1:0] sq_s2;
	logic [DIST_W-1:0]            sum_d;

	// Difference of two in-range values needs one extra bit; its magnitude
	// fits back in ELEM_BITS, so each square fits in twice that.
	always_comb begin
		logic signed [ELEM_BITS:0] diff;
		logic [ELEM_BITS-1:0]      mag;
		for (int d = 0; d < SUB_DIM; d++) begin
			diff = (ELEM_BITS+1)'($signed(tgt[d*ELEM_BITS +: ELEM_BITS]))
				- (ELEM_BITS+1)'($signed(row_s1[d*ELEM_BITS +: ELEM_BITS]));
			mag = diff[ELEM_BITS] ? ELEM_BITS'(-diff) : ELEM_BITS'(diff);
			sq_d[d] = SQ_W'(mag) * SQ_W'(mag);
		end
	end

	always_comb begin
		sum_d = '0;
		for (int d = 0; d < SUB_DIM; d++) begin
			sum_d = sum_d + DIST_W'(sq_s2[d]);
		end
	end

	always_ff @(posedge clk) begin
		sq_s2   <= sq_d;
		dist_s3 <= sum_d;
	end

endmodule

/* dv/split_vq_nearest_search_tb.sv */
module split_vq_nearest_search_tb;

	import svq_pkg::*;

	// Codebook sizing, taken from the package defaults that the block itself uses.
	localparam int NUM_SPLITS   = svq_pkg::NUM_SPLITS_DEF;
	localparam int BOOK_ENTRIES = svq_pkg::BOOK_ENTRIES_DEF;
	localparam int SUB_DIM      = svq_pkg::SUB_DIM_DEF;
	localparam int BOOK_ROWS    = NUM_SPLITS * BOOK_ENTRIES;

	// The fourth opcode carries no meaning; the block must swallow it without a result.
	localparam logic [1:0] OP_IGNORED = 2'd3;

	// Number of random transactions that do real work (ignored opcodes are not counted).
	localparam int RANDOM_ITEMS = 200;
	localparam int MAX_IDLE     = 12;
	localparam int MAX_PRINTED  = 30;

	// One component vector, element 0 in the low bits.
	typedef logic [3:0][15:0] vec4_t;

	// A queued command with the idle gap the sender observes before presenting it.
	// A hold entry makes the sender wait until every expected result has come back.
	typedef struct {
		svq_cmd_t c;
		int       gap;
		bit       hold;
	} pending_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	svq_cmd_t    cmd    = '0;
	logic        busy;
	logic        done;
	svq_result_t result;

	split_vq_nearest_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Commands waiting to be sent, and the results that accepted commands must produce.
	pending_t    cmd_backlog [$];
	svq_result_t expected_codes [$];

	// Our own copy of the codebook, updated as each transaction is accepted.
	logic [15:0] book_copy [BOOK_ROWS][SUB_DIM];

	// The stimulus generator keeps a separate picture of the codebook so that it can aim
	// quantise targets close to real entries. It runs ahead of the block, in queue order.
	vec4_t       gen_book [BOOK_ROWS];
	vec4_t       palette [16];
	int          burst_left = 0;

	int          mismatch_count  = 0;
	int          results_checked = 0;
	int          writes_taken    = 0;
	int          quants_taken    = 0;
	int          deqs_taken      = 0;
	int          ignored_taken   = 0;
	int          holds_done      = 0;
	longint      cycle_count     = 0;
	longint      cycle_limit     = 64'd4_000_000;

	// Driver working variables.
	int          gap_left;
	bit          gap_armed;
	bit          launch;
	pending_t    slot;
	svq_cmd_t    next_cmd;
	logic [95:0] junk;
	svq_result_t fresh_result;

	// Monitor working variable.
	svq_result_t want;

	// Clock with a period of 12 time units.
	initial begin
		forever #6 clk = ~clk;
	end

	// Every mismatch goes through here. Printing stops after a while so that a badly
	// broken block cannot flood the log, but the count keeps going.
	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] wanted);
		if (got !== wanted)
			report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got),
				$signed(wanted)));
	endtask

	// Works out what the block must return for one command, and applies any codebook
	// write to our copy. Returns 1 when the command produces a result.
	// A quantise sums exact squared differences over every entry of the split; only a
	// strictly smaller distance displaces the current best, so on a tie the lowest
	// index wins. A dequantise past the last entry is pinned to the last entry.
	function automatic bit predict_result(input svq_cmd_t c, output svq_result_t r);
		logic [15:0] tgt [SUB_DIM];
		int unsigned base;
		int unsigned row;
		int unsigned i;
		longint      sq_sum;
		longint      best;
		longint      diff;
		int          d;
		r = '0;
		tgt[0] = c.elem0;
		tgt[1] = c.elem1;
		tgt[2] = c.elem2;
		tgt[3] = c.elem3;
		if (c.opcode == OP_IGNORED || c.split_sel >= NUM_SPLITS)
			return 1'b0;
		base = c.split_sel * BOOK_ENTRIES;
		if (c.opcode == OP_WRITE) begin
			if (c.entry_sel < BOOK_ENTRIES) begin
				for (d = 0; d < SUB_DIM; d++)
					book_copy[base + c.entry_sel][d] = tgt[d];
			end
			return 1'b0;
		end
		if (c.opcode == OP_DEQUANT) begin
			row = (c.entry_sel < BOOK_ENTRIES) ? c.entry_sel : BOOK_ENTRIES - 1;
		end else begin
			row = 0;
			best = 0;
			for (i = 0; i < BOOK_ENTRIES; i++) begin
				sq_sum = 0;
				for (d = 0; d < SUB_DIM; d++) begin
					diff = longint'($signed(tgt[d])) - longint'($signed(book_copy[base + i][d]));
					sq_sum += diff * diff;
				end
				if (i == 0 || sq_sum < best) begin
					best = sq_sum;
					row = i;
				end
			end
		end
		r.code_index = row[7:0];
		r.quant0 = book_copy[base + row][0];
		r.quant1 = book_copy[base + row][1];
		r.quant2 = book_copy[base + row][2];
		r.quant3 = book_copy[base + row][3];
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic svq_cmd_t make_cmd(input logic [1:0] op, input logic [1:0] sp,
			input logic [7:0] en, input vec4_t v);
		svq_cmd_t c;
		c.opcode    = op;
		c.split_sel = sp;
		c.entry_sel = en;
		c.elem0     = v[0];
		c.elem1     = v[1];
		c.elem2     = v[2];
		c.elem3     = v[3];
		return c;
	endfunction

	function automatic logic [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// Moves a component by a random amount within +/- spread, saturating at the rails.
	function automatic logic [15:0] nudge(input logic [15:0] x, input int spread);
		return clamp16(int'($signed(x)) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic logic [15:0] rail_value();
		return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
	endfunction

	// Each split gets a content style of its own so that the searches behave differently:
	// split 0 is spread over the full range, split 1 is crowded near zero, split 2 draws
	// from a small palette so that equal distances are common, and split 3 mixes values on
	// the rails with random ones.
	function automatic vec4_t styled_vec(input int sp);
		vec4_t v;
		int    k;
		if (sp == 2)
			return palette[$urandom_range(0, 15)];
		for (k = 0; k < 4; k++) begin
			case (sp)
				0:       v[k] = 16'($urandom);
				1:       v[k] = clamp16(int'($urandom_range(0, 511)) - 256);
				default: v[k] = ($urandom_range(0, 3) == 0) ? rail_value() : 16'($urandom);
			endcase
		end
		return v;
	endfunction

	// Quantise targets: mostly near an existing entry (tight or loose), some exact hits,
	// some anywhere in the range, and some pinned to the rails.
	function automatic vec4_t quant_target(input int sp);
		vec4_t       v;
		int unsigned pick;
		int unsigned row;
		int          spread;
		int          k;
		pick   = $urandom_range(0, 99);
		row    = sp * BOOK_ENTRIES + $urandom_range(0, BOOK_ENTRIES - 1);
		spread = $urandom_range(0, 1) ? 6 : 700;
		if (pick < 15)
			return gen_book[row];
		for (k = 0; k < 4; k++) begin
			if (pick < 60)
				v[k] = nudge(gen_book[row][k], spread);
			else if (pick < 88)
				v[k] = 16'($urandom);
			else
				v[k] = rail_value();
		end
		return v;
	endfunction

	// Queues one command with its idle gap. Gaps are drawn from 0 to MAX_IDLE, apart from
	// occasional runs of back-to-back transactions.
	task automatic queue_cmd(input svq_cmd_t c);
		pending_t p;
		p.c    = c;
		p.hold = 1'b0;
		if (burst_left > 0) begin
			p.gap = 0;
			burst_left--;
		end else begin
			p.gap = $urandom_range(0, MAX_IDLE);
			if ($urandom_range(0, 39) == 0)
				burst_left = $urandom_range(10, 40);
		end
		if (c.opcode == OP_WRITE)
			gen_book[c.split_sel * BOOK_ENTRIES + c.entry_sel] = {c.elem3, c.elem2, c.elem1,
				c.elem0};
		cmd_backlog.push_back(p);
	endtask

	task automatic queue_hold();
		pending_t p;
		p.c    = '0;
		p.gap  = 0;
		p.hold = 1'b1;
		cmd_backlog.push_back(p);
	endtask

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	// A transaction is taken at a rising edge where start is high and busy is low. Here we
	// first book the transaction that has just gone in (predicting its result), then decide
	// what to present next. While start is high and busy is high everything holds still.
	// When nothing is being presented, cmd carries random junk that the block must ignore.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			cmd       <= '0;
			gap_armed = 1'b0;
			gap_left  = 0;
		end else begin
			if (start && !busy) begin
				case (cmd.opcode)
					OP_WRITE:   writes_taken++;
					OP_QUANT:   quants_taken++;
					OP_DEQUANT: deqs_taken++;
					default:    ignored_taken++;
				endcase
				if (predict_result(cmd, fresh_result))
					expected_codes.push_back(fresh_result);
			end
			if (!start || !busy) begin
				launch = 1'b0;
				if (cmd_backlog.size() != 0) begin
					if (cmd_backlog[0].hold) begin
						// Let the block drain completely before carrying on.
						if (expected_codes.size() == 0) begin
							slot = cmd_backlog.pop_front();
							holds_done++;
						end
					end else begin
						if (!gap_armed) begin
							gap_left  = cmd_backlog[0].gap;
							gap_armed = 1'b1;
						end
						if (gap_left == 0) begin
							slot      = cmd_backlog.pop_front();
							next_cmd  = slot.c;
							launch    = 1'b1;
							gap_armed = 1'b0;
						end else begin
							gap_left--;
						end
					end
				end
				junk = {$urandom, $urandom, $urandom};
				start <= launch;
				cmd   <= launch ? next_cmd : junk[$bits(svq_cmd_t)-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	// A result lives on the ports for exactly one cycle with done high; it is taken at the
	// edge that ends that cycle and checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("result index %0d arrived with nothing expected",
					result.code_index));
			end else begin
				want = expected_codes.pop_front();
				check_field("code_index", {8'd0, result.code_index}, {8'd0, want.code_index});
				check_field("quant0", result.quant0, want.quant0);
				check_field("quant1", result.quant1, want.quant1);
				check_field("quant2", result.quant2, want.quant2);
				check_field("quant3", result.quant3, want.quant3);
				results_checked++;
			end
		end
	end

	// Watchdog: a missing result or a block stuck busy ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("timeout after %0d cycles, %0d results outstanding, %0d commands unsent",
				cycle_count, expected_codes.size(), cmd_backlog.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int          k;
		int          n;
		int          sp;
		int          en;
		int          pick;
		int          tmp;
		int          order [BOOK_ENTRIES];
		vec4_t       v;

		for (k = 0; k < 16; k++)
			palette[k] = {clamp16(int'($urandom_range(0, 2047)) - 1024),
				clamp16(int'($urandom_range(0, 2047)) - 1024),
				clamp16(int'($urandom_range(0, 2047)) - 1024),
				clamp16(int'($urandom_range(0, 2047)) - 1024)};

		// Directed opening. Only entries written here are read back, since the codebook
		// holds nothing meaningful until it has been written. Rail values, alternating
		// bit patterns and both ignored-opcode extremes are covered.
		queue_cmd(make_cmd(OP_WRITE, 2'd1, 8'd0, {4{16'h7fff}}));
		queue_cmd(make_cmd(OP_WRITE, 2'd1, 8'd255, {4{16'h8000}}));
		queue_cmd(make_cmd(OP_WRITE, 2'd2, 8'd170, {16'haaaa, 16'h5555, 16'haaaa, 16'h5555}));
		queue_cmd(make_cmd(OP_WRITE, 2'd3, 8'd85, {16'h5555, 16'haaaa, 16'h5555, 16'haaaa}));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd1, 8'd0, '0));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd1, 8'd255, {4{16'hffff}}));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd2, 8'd170, '0));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd3, 8'd85, '0));
		queue_cmd(make_cmd(OP_IGNORED, 2'd0, 8'd0, '0));
		queue_cmd(make_cmd(OP_IGNORED, 2'd3, 8'd255, {4{16'hffff}}));
		queue_cmd(make_cmd(OP_WRITE, 2'd1, 8'd0, {16'h1000, 16'h0000, 16'h0001, 16'hffff}));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd1, 8'd0, '0));

		// Load every entry of splits 0 and 2 in a shuffled order, each in its own style.
		// Quantise walks a whole split, so only these two are searched, and nothing is
		// searched before the load completes.
		for (sp = 0; sp < NUM_SPLITS; sp += 2) begin
			for (k = 0; k < BOOK_ENTRIES; k++)
				order[k] = k;
			for (k = BOOK_ENTRIES - 1; k > 0; k--) begin
				n = $urandom_range(0, k);
				tmp = order[k];
				order[k] = order[n];
				order[n] = tmp;
			end
			for (k = 0; k < BOOK_ENTRIES; k++)
				queue_cmd(make_cmd(OP_WRITE, 2'(sp), 8'(order[k]), styled_vec(sp)));
		end
		queue_hold();

		// Directed searches: targets on both rails against rail entries (largest possible
		// distances), an exact palette hit where many entries tie, an exact hit on the last
		// entry, a zero target among palette values close to zero, and reads of end entries.
		queue_cmd(make_cmd(OP_WRITE, 2'd0, 8'd0, {4{16'h8000}}));
		queue_cmd(make_cmd(OP_WRITE, 2'd0, 8'd1, {4{16'h7fff}}));
		queue_cmd(make_cmd(OP_QUANT, 2'd0, 8'd0, {4{16'h7fff}}));
		queue_cmd(make_cmd(OP_QUANT, 2'd0, 8'd255, {4{16'h8000}}));
		queue_cmd(make_cmd(OP_QUANT, 2'd2, 8'hff, palette[0]));
		queue_cmd(make_cmd(OP_QUANT, 2'd0, 8'd0, gen_book[BOOK_ENTRIES - 1]));
		queue_cmd(make_cmd(OP_QUANT, 2'd2, 8'd0, '0));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd0, 8'd255, '0));
		queue_cmd(make_cmd(OP_DEQUANT, 2'd2, 8'd0, '0));

		// Random part. Splits 0 and 2 are written in full, so random traffic stays on them
		// and may read any index. Rewrites sometimes copy another entry of the same split
		// to create fresh ties.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			sp   = 2 * $urandom_range(0, 1);
			en   = $urandom_range(0, BOOK_ENTRIES - 1);
			if (pick < 35) begin
				queue_cmd(make_cmd(OP_QUANT, 2'(sp), 8'($urandom), quant_target(sp)));
			end else if (pick < 62) begin
				queue_cmd(make_cmd(OP_DEQUANT, 2'(sp), 8'(en), {$urandom, $urandom}));
			end else if (pick < 90) begin
				if ($urandom_range(0, 9) < 3)
					v = gen_book[sp * BOOK_ENTRIES + $urandom_range(0, BOOK_ENTRIES - 1)];
				else
					v = styled_vec(sp);
				queue_cmd(make_cmd(OP_WRITE, 2'(sp), 8'(en), v));
			end else begin
				queue_cmd(make_cmd(OP_IGNORED, 2'(sp), 8'(en), {$urandom, $urandom}));
			end
			if (pick < 90) begin
				n++;
				if (n % 100 == 0)
					queue_hold();
			end
		end

		// Slowest legal case per command: a full search plus the longest sender gap.
		cycle_limit = longint'(cmd_backlog.size()) * (BOOK_ENTRIES + 5 + MAX_IDLE + 2) * 3
			+ 5000;

		// Single reset at the start, released away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (expected_codes.size() != 0)
			@(posedge clk);
		// Give the block a full search time to show any stray result.
		repeat (BOOK_ENTRIES + 10) @(posedge clk);

		$display("run covered %0d writes, %0d searches, %0d lookups and %0d ignored commands",
			writes_taken, quants_taken, deqs_taken, ignored_taken);
		$display("%0d results checked, %0d drain pauses, %0d mismatches",
			results_checked, holds_done, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
